### rtl/core/scv_pkg.sv
// Shared types and constants for the smoothed control value block.
// Depends on nothing; every other file imports it.
package scv_pkg;

   // Item field widths
   localparam int OP_W  = 3;
   localparam int VAL_W = 32;    // signed Q23.8 value and target
   localparam int FAC_W = 16;    // signed Q7.8 scale factor
   localparam int FRAC_W = 8;    // fraction bits of Q23.8

   // Register widths
   localparam int INT_W   = 24;  // integer registers (default, limits, deadband)
   localparam int GAIN_W  = 17;
   localparam int MSTEP_W = 23;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // Datapath widths
   localparam int TGT_W  = 41;               // update target, covers scaled value
   localparam int DIF_W  = 42;               // target minus value
   localparam int MULA_W = GAIN_W + 1;       // signed operand a of the multiplier
   localparam int PROD_W = MULA_W + DIF_W;
   localparam int FD_W   = PROD_W - 16;      // gain times difference, Q0.16 dropped
   localparam int ARG_W  = 45;               // pre-clamp value

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_RESET    = 3'd0,
      OP_FORCE    = 3'd1,
      OP_AT_LEAST = 3'd2,
      OP_NO_MORE  = 3'd3,
      OP_UPDATE   = 3'd4,
      OP_SCALE    = 3'd5,
      OP_DECAY    = 3'd6
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGT,
      ST_DIFF,
      ST_MUL,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic signed [INT_W-1:0]  default_value;
      logic signed [INT_W-1:0]  lower_limit;
      logic signed [INT_W-1:0]  upper_limit;
      logic [GAIN_W-1:0]        gain;
      logic [MSTEP_W-1:0]       min_step;
      logic signed [INT_W-1:0]  deadband;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // latch the accepted item
      logic tgt;     // form the update target
      logic diff;    // target minus value
      logic mul;     // gain times difference
      logic apply;   // commit the new value
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic upd_in;  // incoming item is update, scale or decay
   } sts_type;

endpackage

### rtl/core/scv_if.sv
// Item channel interfaces for the smoothed control value block.
// Depends on scv_pkg.
interface scv_req_if;
   import scv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [VAL_W-1:0] target;
   logic signed [FAC_W-1:0] factor;
   logic                    arm_first;

   modport source (output valid, output operation, output target, output factor,
                   output arm_first, input ready);
   modport sink   (input valid, input operation, input target, input factor,
                   input arm_first, output ready);
endinterface

interface scv_rsp_if;
   import scv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### rtl/core/smoothed_control_value.sv
// Top level of the smoothed control value block.
// Depends on scv_pkg, scv_if, scv_csr, scv_ctrl and scv_datapath.
//
// Holds one signed Q23.8 control value and a first-update flag. Each item on
// the request channel names an operation (reset, force, at_least, no_more,
// update, scale, decay) and every item returns the value after it. Updates
// move the value by gain times the difference, subject to deadband and
// min_step, then clamp to the limits and saturate to 32 bits. Reset, force,
// at_least, no_more and the unused code go accept, commit; update, scale and
// decay go accept, target, difference, multiply, commit, using the one shared
// 18 x 42 multiplier for the scale and the gain product. The value register
// is the result register: a new item is taken while a result waits, and its
// commit holds until that result is taken. Registers are written on csr_we;
// the user writes them only while idle, which the block does not enforce.
module smoothed_control_value (
   input  logic                           clock,
   input  logic                           reset,
   scv_req_if.sink                        req_port,
   scv_rsp_if.source                      rsp_port,
   input  logic                           csr_we,
   input  logic [scv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scv_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import scv_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // register file
   scv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: handshakes and step commands
   scv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // value, multiplier and clamps; the value drives the result item directly
   scv_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cfg          (cfg),
      .in_operation (req_port.operation),
      .in_target    (req_port.target),
      .in_factor    (req_port.factor),
      .in_arm_first (req_port.arm_first),
      .value        (rsp_port.value)
   );

endmodule

### rtl/core/scv_csr.sv
// Configuration registers of the smoothed control value block.
// Depends on scv_pkg.
module scv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [scv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output scv_pkg::cfg_type                cfg
);
   import scv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT:  cfg_in.default_value = $signed(csr_wdata[INT_W-1:0]);
            CSR_LOWER:    cfg_in.lower_limit   = $signed(csr_wdata[INT_W-1:0]);
            CSR_UPPER:    cfg_in.upper_limit   = $signed(csr_wdata[INT_W-1:0]);
            CSR_GAIN:     cfg_in.gain          = csr_wdata[GAIN_W-1:0];
            CSR_MIN_STEP: cfg_in.min_step      = csr_wdata[MSTEP_W-1:0];
            CSR_DEADBAND: cfg_in.deadband      = $signed(csr_wdata[INT_W-1:0]);
            default:      cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_value <= '0;
         cfg_ff.lower_limit   <= '0;
         cfg_ff.upper_limit   <= '0;
         cfg_ff.gain          <= GAIN_RESET;
         cfg_ff.min_step      <= '0;
         cfg_ff.deadband      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/scv_ctrl.sv
// Sequencing controller of the smoothed control value block.
// Depends on scv_pkg.
module scv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  scv_pkg::sts_type  sts,
   output scv_pkg::cmd_type  cmd
);
   import scv_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.upd_in ? ST_TGT : ST_APPLY;
            end
         end
         ST_TGT: begin
            cmd.tgt  = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // value register doubles as the result register: commit only once
            // the previous result has left
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/scv_datapath.sv
// Datapath of the smoothed control value block: value, shared multiplier,
// smoothing step, clamps. Depends on scv_pkg.
module scv_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  scv_pkg::cmd_type              cmd,
   output scv_pkg::sts_type              sts,
   input  scv_pkg::cfg_type              cfg,
   input  logic [scv_pkg::OP_W-1:0]      in_operation,
   input  logic signed [scv_pkg::VAL_W-1:0] in_target,
   input  logic signed [scv_pkg::FAC_W-1:0] in_factor,
   input  logic                          in_arm_first,
   output logic signed [scv_pkg::VAL_W-1:0] value
);
   import scv_pkg::*;

   localparam logic signed [ARG_W-1:0] SAT_HI = ARG_W'(2**(VAL_W-1) - 1);
   localparam logic signed [ARG_W-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [VAL_W-1:0] clamp_val(
      input logic signed [ARG_W-1:0] x,
      input logic signed [VAL_W-1:0] lo,
      input logic signed [VAL_W-1:0] hi);
      logic signed [ARG_W-1:0] r;
      r = x;
      if (hi > lo) begin
         if (r > ARG_W'(hi)) r = ARG_W'(hi);
         if (r < ARG_W'(lo)) r = ARG_W'(lo);
      end
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return VAL_W'(r);
   endfunction

   // item registers
   logic [OP_W-1:0]          op_ff;
   logic signed [VAL_W-1:0]  tgt_ff;
   logic signed [FAC_W-1:0]  fac_ff;
   logic                     arm_ff;
   // work registers
   logic signed [TGT_W-1:0]  t_ff;
   logic signed [DIF_W-1:0]  d_ff;
   logic signed [FD_W-1:0]   fd_ff;
   // state
   logic signed [VAL_W-1:0]  v_ff, v_in;
   logic                     first_ff, first_in;

   logic signed [VAL_W-1:0]  dflt_q8, lo_q8, hi_q8, tol_q8, mstep_q8;
   logic signed [MULA_W-1:0] mul_a;
   logic signed [DIF_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [ARG_W-1:0]  d_x, nd_x, fd_x, nfd_x, v_x, ad_x, tol_x, m_x;
   logic signed [ARG_W-1:0]  lim, step, upd_arg, clamp_in;
   logic                     copy, hold, keep;
   logic signed [VAL_W-1:0]  clamped;

   assign dflt_q8  = $signed({cfg.default_value, {FRAC_W{1'b0}}});
   assign lo_q8    = $signed({cfg.lower_limit, {FRAC_W{1'b0}}});
   assign hi_q8    = $signed({cfg.upper_limit, {FRAC_W{1'b0}}});
   assign tol_q8   = $signed({cfg.deadband, {FRAC_W{1'b0}}});
   assign mstep_q8 = $signed({1'b0, cfg.min_step, {FRAC_W{1'b0}}});

   assign sts.upd_in = (in_operation == OP_UPDATE) || (in_operation == OP_SCALE) ||
                       (in_operation == OP_DECAY);

   // shared multiplier: factor x value for scale, gain x difference for the step
   assign mul_a = cmd.mul ? $signed({1'b0, cfg.gain}) : MULA_W'(fac_ff);
   assign mul_b = cmd.mul ? d_ff : DIF_W'(v_ff);
   assign prod  = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_operation;
         tgt_ff <= in_target;
         fac_ff <= in_factor;
         arm_ff <= in_arm_first;
      end
      if (cmd.tgt) begin
         unique case (op_ff)
            OP_SCALE: t_ff <= TGT_W'(prod >>> FRAC_W);
            OP_DECAY: t_ff <= TGT_W'(dflt_q8);
            default:  t_ff <= TGT_W'(tgt_ff);
         endcase
      end
      if (cmd.diff) d_ff  <= DIF_W'(t_ff) - DIF_W'(v_ff);
      if (cmd.mul)  fd_ff <= FD_W'(prod >>> 16);
   end

   // smoothing step
   always_comb begin
      d_x   = ARG_W'(d_ff);
      nd_x  = -d_x;
      fd_x  = ARG_W'(fd_ff);
      nfd_x = -fd_x;
      v_x   = ARG_W'(v_ff);
      ad_x  = d_ff[DIF_W-1] ? nd_x : d_x;
      tol_x = ARG_W'(tol_q8);
      m_x   = ARG_W'(mstep_q8);
      copy  = (tol_x < 0) && (ad_x > -tol_x);
      hold  = (tol_x > 0) && (ad_x <= tol_x);
      keep  = !first_ff && !copy && hold;
      if (d_ff[DIF_W-1]) begin
         lim  = (nd_x < m_x) ? nd_x : m_x;
         step = (nfd_x > lim) ? nfd_x : lim;
      end else begin
         lim  = (d_x < m_x) ? d_x : m_x;
         step = (fd_x > lim) ? fd_x : lim;
      end
      priority if (first_ff || copy) upd_arg = ARG_W'(t_ff);
      else if (m_x == 0)             upd_arg = v_x + fd_x;
      else if (d_ff[DIF_W-1])        upd_arg = v_x - step;
      else                           upd_arg = v_x + step;
      clamp_in = (op_ff == OP_FORCE) ? ARG_W'(tgt_ff) : upd_arg;
      clamped  = clamp_val(clamp_in, lo_q8, hi_q8);
   end

   always_comb begin
      v_in     = v_ff;
      first_in = first_ff;
      if (cmd.apply) begin
         unique case (op_ff)
            OP_RESET: begin
               v_in     = dflt_q8;
               first_in = arm_ff;
            end
            OP_FORCE: begin
               v_in     = clamped;
               first_in = 1'b0;
            end
            OP_AT_LEAST: if (v_ff < tgt_ff) v_in = tgt_ff;
            OP_NO_MORE:  if (v_ff > tgt_ff) v_in = tgt_ff;
            OP_UPDATE, OP_SCALE, OP_DECAY: begin
               if (!keep) begin
                  v_in     = clamped;
                  first_in = 1'b0;
               end
            end
            default: v_in = v_ff;   // unused code: no change
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         first_ff <= 1'b0;
      end else begin
         v_ff     <= v_in;
         first_ff <= first_in;
      end
   end

   assign value = v_ff;

endmodule

### tb/smoothed_control_value_tb.sv
// Self-checking testbench for the smoothed control value block.
// Depends on scv_pkg, the scv_req_if / scv_rsp_if interfaces and the RTL.
// A local model predicts every returned value; random gaps on both channels.
module smoothed_control_value_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scv_pkg::*;

   // Unused operation code: block must return the value untouched
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_TOP = 32'h7fff_ffff;
   localparam logic signed [VAL_W-1:0] VAL_BOT = 32'h8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEMS_PER_PHASE = 123;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic signed [VAL_W-1:0] target;
      logic signed [FAC_W-1:0] factor;
      logic                    arm_first;
   } ctl_item_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   scv_req_if req_ch ();
   scv_rsp_if rsp_ch ();

   smoothed_control_value u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Local copy of the block: registers and state at their reset values
   // ---------------------------------------------------------------------
   logic signed [INT_W-1:0] cfg_default  = '0;
   logic signed [INT_W-1:0] cfg_lower    = '0;
   logic signed [INT_W-1:0] cfg_upper    = '0;
   logic [GAIN_W-1:0]       cfg_gain     = GAIN_RESET;
   logic [MSTEP_W-1:0]      cfg_min_step = '0;
   logic signed [INT_W-1:0] cfg_deadband = '0;

   logic signed [VAL_W-1:0] ctl_value   = '0;
   bit                      first_armed = 1'b0;

   ctl_item_t               pending_items[$];    // waiting for the driver
   logic signed [VAL_W-1:0] expected_values[$];  // predicted, not yet returned

   int  error_count = 0;
   int  cycle_count = 0;
   bit  req_taken   = 1'b0;   // handshake seen at the last rising edge
   bit  rsp_taken   = 1'b0;
   int  send_gap    = 0;
   int  recv_hold   = 0;
   bit  send_burst  = 1'b0;   // burst: no gaps at all for a while
   bit  recv_burst  = 1'b0;
   ctl_item_t next_item;
   logic signed [VAL_W-1:0] last_target = '0;

   // Clamp to the limits when they form a range, saturate to 32 bits,
   // store; any forced value also clears the first-update flag.
   function automatic void clamp_and_store(longint t);
      longint lo, hi;
      lo = longint'(cfg_lower) * 256;
      hi = longint'(cfg_upper) * 256;
      first_armed = 1'b0;
      if (hi > lo) begin
         if (t > hi) t = hi;
         if (t < lo) t = lo;
      end
      if (t > SAT_HI) t = SAT_HI;
      if (t < SAT_LO) t = SAT_LO;
      ctl_value = t[VAL_W-1:0];
   endfunction

   // One smoothing step toward t (t kept exact, up to 40 bits)
   function automatic void smooth_toward(longint t);
      longint v, d, ad, tol, m, fd, step;
      v   = ctl_value;
      d   = t - v;
      ad  = (d < 0) ? -d : d;
      tol = longint'(cfg_deadband) * 256;
      m   = longint'(cfg_min_step) * 256;
      fd  = (longint'(cfg_gain) * d) >>> 16;   // floor, like the hardware shift
      if (first_armed) begin
         clamp_and_store(t);
      end else if (tol < 0 && ad > -tol) begin
         clamp_and_store(t);                   // big jump: copy it
      end else if (tol > 0 && ad <= tol) begin
         // inside the deadband: hold
      end else if (m <= 0) begin
         clamp_and_store(v + fd);
      end else if (d >= 0) begin
         step = (d < m) ? d : m;
         if (fd > step) step = fd;
         clamp_and_store(v + step);
      end else begin
         step = (-d < m) ? -d : m;
         if (-fd > step) step = -fd;
         clamp_and_store(v - step);
      end
   endfunction

   // Apply one accepted item; returns the value the block must return
   function automatic logic signed [VAL_W-1:0] next_control_value(ctl_item_t it);
      case (it.op)
         OP_RESET: begin
            ctl_value   = {cfg_default, 8'h00};
            first_armed = it.arm_first;
         end
         OP_FORCE:    clamp_and_store(longint'(it.target));
         OP_AT_LEAST: if (ctl_value < it.target) ctl_value = it.target;
         OP_NO_MORE:  if (ctl_value > it.target) ctl_value = it.target;
         OP_UPDATE:   smooth_toward(longint'(it.target));
         OP_SCALE:    smooth_toward((longint'(it.factor) * longint'(ctl_value)) >>> 8);
         OP_DECAY:    smooth_toward(longint'(cfg_default) * 256);
         default: begin
            // unused code: no change
         end
      endcase
      return ctl_value;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   function automatic int rand_span(int lo, int hi);
      return lo + int'($urandom_range(32'(hi - lo)));
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int idle_len(bit burst);
      int r;
      r = $urandom_range(99);
      if (burst || r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 7)  return OP_RESET;
      if (r < 17) return OP_FORCE;
      if (r < 24) return OP_AT_LEAST;
      if (r < 31) return OP_NO_MORE;
      if (r < 66) return OP_UPDATE;
      if (r < 78) return OP_SCALE;
      if (r < 93) return OP_DECAY;
      return OP_UNUSED;
   endfunction

   // Targets cluster around the last one so the deadband and min step
   // see small differences; the rest spread out up to full range.
   function automatic logic signed [VAL_W-1:0] pick_target();
      int r;
      r = $urandom_range(99);
      if (r < 45)      last_target = last_target + rand_span(-4096, 4096);
      else if (r < 80) last_target = rand_span(-(2**21), 2**21);
      else if (r < 92) last_target = $urandom();
      else begin
         case ($urandom_range(3))
            0: last_target = VAL_TOP;
            1: last_target = VAL_BOT;
            2: last_target = '0;
            default: last_target = '1;
         endcase
      end
      return last_target;
   endfunction

   function automatic logic signed [FAC_W-1:0] pick_factor();
      int r;
      r = $urandom_range(99);
      if (r < 50) return FAC_W'(256 + rand_span(-64, 64));   // near 1.0
      if (r < 80) return FAC_W'(rand_span(-1024, 1024));
      return FAC_W'($urandom());
   endfunction

   task automatic push_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] t,
                            input logic signed [FAC_W-1:0] f, input logic arm);
      ctl_item_t it;
      it.op        = op;
      it.target    = t;
      it.factor    = f;
      it.arm_first = arm;
      pending_items.push_back(it);
   endtask

   task automatic add_random_items(input int n);
      repeat (n) push_item(pick_op(), pick_target(), pick_factor(), 1'($urandom()));
   endtask

   // ---------------------------------------------------------------------
   // Register writes (called at a falling edge, block idle)
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      case (idx)
         CSR_DEFAULT:  cfg_default  = INT_W'(data);
         CSR_LOWER:    cfg_lower    = INT_W'(data);
         CSR_UPPER:    cfg_upper    = INT_W'(data);
         CSR_GAIN:     cfg_gain     = GAIN_W'(data);
         CSR_MIN_STEP: cfg_min_step = MSTEP_W'(data);
         CSR_DEADBAND: cfg_deadband = INT_W'(data);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input int dflt, input int lo, input int hi,
                             input int g, input int mstep, input int db);
      write_reg(CSR_DEFAULT, dflt);
      write_reg(CSR_LOWER, lo);
      write_reg(CSR_UPPER, hi);
      write_reg(CSR_GAIN, g);
      write_reg(CSR_MIN_STEP, mstep);
      write_reg(CSR_DEADBAND, db);
      csr_we <= 1'b0;
   endtask

   // Every item returns a result, so an empty prediction queue with the
   // channel quiet means the block is idle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_values.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: next item or a gap at the falling edge after acceptance
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!req_ch.valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_ch.operation <= next_item.op;
            req_ch.target    <= next_item.target;
            req_ch.factor    <= next_item.factor;
            req_ch.arm_first <= next_item.arm_first;
            req_ch.valid     <= 1'b1;
            send_gap = idle_len(send_burst);
            if ($urandom_range(47) == 0) send_burst = !send_burst;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side: ready may stall for a random gap after each taken result
   always @(negedge clock) begin
      if (recv_hold != 0) begin
         recv_hold = recv_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_taken) begin
            recv_hold = idle_len(recv_burst);
            if ($urandom_range(47) == 0) recv_burst = !recv_burst;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on request accept, check on result accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ctl_item_t seen;
      logic signed [VAL_W-1:0] want;
      cycle_count++;
      req_taken = !reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
      rsp_taken = !reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
      // check before predicting, so a result can never match the item
      // accepted at this same edge
      if (rsp_taken) begin
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_ch.value));
         end else begin
            want = expected_values.pop_front();
            if (rsp_ch.value !== want)
               report_mismatch($sformatf("value %h, expected %h", rsp_ch.value, want));
         end
      end
      if (req_taken) begin
         seen.op        = req_ch.operation;
         seen.target    = req_ch.target;
         seen.factor    = req_ch.factor;
         seen.arm_first = req_ch.arm_first;
         expected_values.push_back(next_control_value(seen));
      end
   end

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(negedge clock);
      $display("smoothed_control_value_tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.target    = '0;
      req_ch.factor    = '0;
      req_ch.arm_first = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed, under the reset settings: limits off, gain about 0.1
      @(posedge clock);
      push_item(OP_RESET,    '0,      '0,          1'b1);  // arm first update
      push_item(OP_UPDATE,   32'sd1000, '0,        1'b0);  // copied
      push_item(OP_UPDATE,   VAL_TOP, '0,          1'b0);
      push_item(OP_FORCE,    VAL_TOP, '0,          1'b1);
      push_item(OP_SCALE,    '0,      16'sh7fff,   1'b0);  // saturates high
      push_item(OP_SCALE,    '0,      16'sh8000,   1'b0);  // saturates low
      push_item(OP_AT_LEAST, VAL_TOP, '0,          1'b0);
      push_item(OP_NO_MORE,  VAL_BOT, '0,          1'b0);
      push_item(OP_DECAY,    '0,      '0,          1'b0);
      push_item(OP_FORCE,    VAL_BOT, '0,          1'b0);
      push_item(OP_UPDATE,   VAL_TOP, '0,          1'b0);  // full 2^32 span
      push_item(OP_AT_LEAST, '1,      '0,          1'b0);
      push_item(OP_NO_MORE,  '0,      '0,          1'b0);
      push_item(OP_UNUSED,   32'h5a5a_a5a5, 16'h55aa, 1'b1);
      push_item(OP_RESET,    '0,      '0,          1'b1);
      push_item(OP_FORCE,    32'sd1280, '0,        1'b0);  // force clears arming
      push_item(OP_UPDATE,   -32'sd256, '0,        1'b0);
      push_item(OP_SCALE,    '0,      16'sd256,    1'b0);
      push_item(OP_SCALE,    '0,      '0,          1'b0);
      push_item(OP_RESET,    '0,      '0,          1'b0);
      push_item(OP_UPDATE,   '0,      '0,          1'b0);
      push_item(OP_DECAY,    '0,      '0,          1'b1);
      wait_idle();

      // Extreme settings first, then random ones
      set_config(-8388608, -8388608, 8388607, 65536, 8388607, -8388608);
      @(posedge clock);
      push_item(OP_RESET, '0, '0, 1'b0);
      push_item(OP_UPDATE, VAL_TOP, '0, 1'b0);
      add_random_items(ITEMS_PER_PHASE);
      wait_idle();

      // gain above one overshoots; limits inverted so they stay off
      set_config(8388607, 100, -100, 131071, 0, 8388607);
      @(posedge clock);
      push_item(OP_FORCE, VAL_BOT, '0, 1'b0);
      push_item(OP_DECAY, '0, '0, 1'b0);
      add_random_items(ITEMS_PER_PHASE);
      wait_idle();

      set_config(0, -50, 50, 0, 1, 1);
      @(posedge clock);
      add_random_items(ITEMS_PER_PHASE);
      wait_idle();

      set_config(5, -2000, 2000, 32768, 3, -10);
      @(posedge clock);
      add_random_items(ITEMS_PER_PHASE);
      wait_idle();

      repeat (6) begin
         set_config(rand_span(-5000, 5000), rand_span(-8000, 4000), rand_span(-4000, 8000),
                    ($urandom_range(3) == 0) ? $urandom_range(131071)
                                             : $urandom_range(65536),
                    ($urandom_range(1) == 0) ? 0 : $urandom_range(400),
                    rand_span(-300, 300));
         @(posedge clock);
         add_random_items(ITEMS_PER_PHASE);
         wait_idle();
      end

      // Quiet tail: any stray result is flagged by the monitor
      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("smoothed_control_value_tb OK");
      else
         $display("smoothed_control_value_tb NOT OK");
      $finish;
   end

endmodule
